// ===== hdl/swr_pkg.sv =====
package swr_pkg;

	// Field widths
	localparam int SEQ_W  = 31;
	localparam int ACK_W  = 32;
	localparam int WIN_W  = 7;
	localparam int CFG_W  = 31;
	localparam int IDX_W  = 1;
	localparam int IN_W   = 32;
	localparam int OUT_W  = 40;

	// Default receive window store depth
	localparam int WINDOW_MAX_DEF = 64;

	// Register indexes
	localparam logic [IDX_W-1:0] REG_WINDOW_SIZE   = 1'b0;
	localparam logic [IDX_W-1:0] REG_MESSAGE_COUNT = 1'b1;

	// Register reset values
	localparam logic [WIN_W-1:0] WINDOW_SIZE_RST   = 7'd64;
	localparam logic [CFG_W-1:0] MESSAGE_COUNT_RST = 31'd20000;

	// Ack value before anything is in order
	localparam logic [ACK_W-1:0] ACK_NONE = '1;

endpackage

// ===== hdl/sliding_window_receiver_core.sv =====
// Receiver side of a sliding-window protocol with cumulative acknowledgment. Each input word
// carries one frame sequence number; each frame gives one output word (none if a window_size
// write cuts the frame off first) holding the cumulative ack (next expected minus one, all
// ones before anything is in order), an accepted flag and a done flag. The received marks
// live in a one-bit synchronous memory of WINDOW_MAX entries that is read, checked and
// written back one entry a cycle. A frame passes through accept, slot address, check and
// output load, and the output load waits while the output register holds an unaccepted
// result. A frame that fills the gap at the window base releases its own slot in the check
// step and then walks over every further slot released, one memory access a cycle, ending
// with one more read. One frame is in flight at a time, while a finished result may still
// wait on the output register. After reset and every window_size write a clearing pass
// sweeps every memory entry, accepting no frame; configuration writes are taken at any time.
module sliding_window_receiver_core #(
	parameter int WINDOW_MAX = swr_pkg::WINDOW_MAX_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	// Configuration write port
	input  logic                      cfg_we,
	input  logic [swr_pkg::IDX_W-1:0] cfg_index,
	input  logic [swr_pkg::CFG_W-1:0] cfg_wdata,
	// Frame input
	input  logic                      s_tvalid,
	output logic                      s_tready,
	input  logic [swr_pkg::IN_W-1:0]  s_tdata,   // [30:0] seq_num, [31] zero
	// Result output
	output logic                      m_tvalid,
	input  logic                      m_tready,
	output logic [swr_pkg::OUT_W-1:0] m_tdata    // [31:0] ack_seq, [32] accepted,
	                                             // [33] done_res, [39:34] zero
);

	localparam int WW = $clog2(WINDOW_MAX + 1);
	localparam int SW = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
	localparam int CW = (WW > swr_pkg::WIN_W) ? WW : swr_pkg::WIN_W;

	localparam logic [2:0] S_CLR  = 3'd0;
	localparam logic [2:0] S_IDLE = 3'd1;
	localparam logic [2:0] S_SLOT = 3'd2;
	localparam logic [2:0] S_CHK  = 3'd3;
	localparam logic [2:0] S_ADV  = 3'd4;
	localparam logic [2:0] S_OUT  = 3'd5;

	// Control state
	logic [2:0]                  state_q;
	logic [SW-1:0]               clr_q;
	logic [swr_pkg::WIN_W-1:0]   window_q;
	logic [swr_pkg::CFG_W-1:0]   mcount_q;
	logic [swr_pkg::SEQ_W-1:0]   next_q;
	logic [SW-1:0]               base_q;
	logic [WW-1:0]               n_q;
	logic                        out_valid_q;

	// Per-frame payload
	logic [WW-1:0]               off_q;
	logic                        in_win_q;
	logic                        zero_off_q;
	logic                        done_q;
	logic                        acc_q;
	logic [SW-1:0]               slot_q;
	logic [swr_pkg::OUT_W-1:0]   out_data_q;

	// Slot memory
	logic                        mem [WINDOW_MAX];
	logic                        rd_q;
	logic                        mem_we;
	logic [SW-1:0]               mem_wa;
	logic                        mem_wd;
	logic [SW-1:0]               mem_ra;

	logic [CW-1:0]               win_ext;
	logic [WW-1:0]               w_eff;
	logic [WW-1:0]               base_p1;
	logic [SW-1:0]               base_inc;
	logic [WW:0]                 slot_sum;
	logic [WW:0]                 slot_mod;
	logic [swr_pkg::SEQ_W-1:0]   seq_in;
	logic [swr_pkg::SEQ_W-1:0]   off_full;
	logic                        in_acc;
	logic                        out_free;
	logic                        fill_hit;
	logic [swr_pkg::ACK_W-1:0]   ack_val;

	assign s_tready = (state_q == S_IDLE);
	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;

	assign in_acc   = s_tvalid && s_tready;
	assign out_free = !out_valid_q || m_tready;
	assign seq_in   = s_tdata[swr_pkg::SEQ_W-1:0];
	assign off_full = seq_in - next_q;

	// Clamp the window to the store depth, a zero window counting as one
	assign win_ext = CW'(window_q);
	always_comb begin
		priority if (win_ext == '0) begin
			w_eff = WW'(1);
		end else if (win_ext > CW'(WINDOW_MAX)) begin
			w_eff = WW'(WINDOW_MAX);
		end else begin
			w_eff = WW'(win_ext);
		end
	end

	// Step the base slot round the window
	assign base_p1  = WW'(base_q) + WW'(1);
	assign base_inc = (base_p1 == w_eff) ? '0 : SW'(base_p1);

	// Slot of the frame: base plus offset, folded once
	assign slot_sum = (WW + 1)'(base_q) + (WW + 1)'(off_q);
	assign slot_mod = (slot_sum >= (WW + 1)'(w_eff)) ? slot_sum - (WW + 1)'(w_eff) : slot_sum;

	// A free in-window slot was found
	assign fill_hit = in_win_q && !rd_q;

	assign ack_val = (next_q == '0) ? swr_pkg::ACK_NONE
	                                : {1'b0, next_q - swr_pkg::SEQ_W'(1)};

	// Memory access select
	always_comb begin
		mem_we = 1'b0;
		mem_wa = slot_q;
		mem_wd = 1'b0;
		mem_ra = SW'(slot_mod);
		unique case (state_q)
			S_CLR: begin
				mem_we = 1'b1;
				mem_wa = clr_q;
			end
			S_CHK: begin
				if (fill_hit) begin
					mem_we = 1'b1;
					if (zero_off_q) begin
						mem_wa = base_q;
						mem_ra = base_inc;
					end else begin
						mem_wd = 1'b1;
					end
				end
			end
			S_ADV: begin
				mem_wa = base_q;
				mem_ra = base_inc;
				mem_we = rd_q && (n_q < w_eff);
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_wa] <= mem_wd;
		end
		rd_q <= mem[mem_ra];
	end

	// Sequencer and configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLR;
			clr_q       <= '0;
			window_q    <= swr_pkg::WINDOW_SIZE_RST;
			mcount_q    <= swr_pkg::MESSAGE_COUNT_RST;
			next_q      <= '0;
			base_q      <= '0;
			n_q         <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && m_tready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_CLR: begin
					clr_q <= clr_q + SW'(1);
					if (clr_q == SW'(WINDOW_MAX - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (in_acc) begin
						state_q <= S_SLOT;
					end
				end
				S_SLOT: begin
					state_q <= S_CHK;
				end
				S_CHK: begin
					if (fill_hit && zero_off_q) begin
						next_q  <= next_q + swr_pkg::SEQ_W'(1);
						base_q  <= base_inc;
						n_q     <= WW'(1);
						state_q <= S_ADV;
					end else begin
						state_q <= S_OUT;
					end
				end
				S_ADV: begin
					if (rd_q && (n_q < w_eff)) begin
						next_q <= next_q + swr_pkg::SEQ_W'(1);
						base_q <= base_inc;
						n_q    <= n_q + WW'(1);
					end else begin
						state_q <= S_OUT;
					end
				end
				S_OUT: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_CLR;
				end
			endcase
			// Register writes; a window write restarts the clearing pass
			if (cfg_we) begin
				unique case (cfg_index)
					swr_pkg::REG_WINDOW_SIZE: begin
						window_q <= cfg_wdata[swr_pkg::WIN_W-1:0];
						base_q   <= '0;
						clr_q    <= '0;
						state_q  <= S_CLR;
					end
					swr_pkg::REG_MESSAGE_COUNT: begin
						mcount_q <= cfg_wdata;
					end
					default: begin
					end
				endcase
			end
		end
	end

	// Frame payload
	always_ff @(posedge clk) begin
		if (in_acc) begin
			off_q      <= off_full[WW-1:0];
			in_win_q   <= (off_full < swr_pkg::SEQ_W'(w_eff));
			zero_off_q <= (off_full == '0);
			done_q     <= (mcount_q != '0) && (seq_in == mcount_q - swr_pkg::CFG_W'(1));
		end
		if (state_q == S_SLOT) begin
			slot_q <= SW'(slot_mod);
		end
		if (state_q == S_CHK) begin
			acc_q <= fill_hit;
		end
		if ((state_q == S_OUT) && out_free) begin
			out_data_q <= {6'd0, done_q, acc_q, ack_val};
		end
	end

endmodule

// ===== hdl/swr_checker.sv =====
module swr_checker (
	input logic                      clk,
	input logic                      arst_n,
	input logic                      cfg_we,
	input logic [swr_pkg::IDX_W-1:0] cfg_index,
	input logic                      s_tvalid,
	input logic                      s_tready,
	input logic                      m_tvalid,
	input logic                      m_tready,
	input logic [swr_pkg::OUT_W-1:0] m_tdata
);

	// Hold a stalled result word
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result word changed while stalled");

	// One frame in flight: no accept straight after an accept
	a_one_frame: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("input ready straight after an accepted word");

	// A window write starts the clearing pass
	a_win_clear: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_we && (cfg_index == swr_pkg::REG_WINDOW_SIZE) |=> !s_tready)
		else $error("input ready during clearing pass");

	// Ack is either none or a non-negative number
	a_ack_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> !m_tdata[swr_pkg::ACK_W-1]
		          || (m_tdata[swr_pkg::ACK_W-1:0] == swr_pkg::ACK_NONE))
		else $error("ack value out of range");

endmodule

bind sliding_window_receiver_core swr_checker u_swr_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.cfg_we    (cfg_we),
	.cfg_index (cfg_index),
	.s_tvalid  (s_tvalid),
	.s_tready  (s_tready),
	.m_tvalid  (m_tvalid),
	.m_tready  (m_tready),
	.m_tdata   (m_tdata)
);
